/* sv/obdr_pkg.sv */
// ----------------------------------------------------------------------------
// obdr_pkg
// Shared types and constants of the diagnostic request and answer reassembly
// unit.
// ----------------------------------------------------------------------------
package obdr_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_REQUEST_ID      = 2'd0;
    localparam logic [1:0] REG_RESPONSE_ID     = 2'd1;
    localparam logic [1:0] REG_FLOW_CONTROL_ID = 2'd2;
    localparam logic [1:0] REG_SERVICE_CODE    = 2'd3;

    // reset values of the registers
    localparam logic [10:0] REQUEST_ID_RST      = 11'h7DF;
    localparam logic [10:0] RESPONSE_ID_RST     = 11'h7E8;
    localparam logic [10:0] FLOW_CONTROL_ID_RST = 11'h7E0;
    localparam logic [7:0]  SERVICE_CODE_RST    = 8'h01;

    // input word types
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_FRAME = 1'b1;

    // result word kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_CHUNK = 1'b1;

    // protocol control bytes
    localparam logic [3:0] PCI_SINGLE_NIBBLE = 4'h0;
    localparam logic [3:0] PCI_CONSEC_NIBBLE = 4'h2;
    localparam logic [7:0] PCI_FIRST_FRAME   = 8'h10;
    localparam logic [7:0] PCI_FLOW_CONTROL  = 8'h30;

    localparam logic [3:0] MAX_FRAME_BYTES = 4'd8;
    localparam logic [3:0] MAX_PIDS        = 4'd6;

    // result queue depth default (two results per word at most)
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic        req_type;
        logic [10:0] frame_id;
        logic [3:0]  frame_len;
        logic [7:0]  data_b0;
        logic [7:0]  data_b1;
        logic [7:0]  data_b2;
        logic [7:0]  data_b3;
        logic [7:0]  data_b4;
        logic [7:0]  data_b5;
        logic [7:0]  data_b6;
        logic [7:0]  data_b7;
    } obdr_in_t;

    typedef struct packed {
        logic        out_kind;
        logic [10:0] out_id;
        logic [3:0]  out_len;
        logic [7:0]  out_b0;
        logic [7:0]  out_b1;
        logic [7:0]  out_b2;
        logic [7:0]  out_b3;
        logic [7:0]  out_b4;
        logic [7:0]  out_b5;
        logic [7:0]  out_b6;
        logic [7:0]  out_b7;
        logic        last_chunk;
    } obdr_out_t;

    typedef struct packed {
        logic [10:0] request_id;
        logic [10:0] response_id;
        logic [10:0] flow_control_id;
        logic [7:0]  service_code;
    } obdr_cfg_t;

    typedef struct packed {
        logic       awaiting_answer;
        logic       in_multi_frame;
        logic [7:0] total_length;
        logic [7:0] bytes_received;
    } obdr_state_t;

    typedef logic [7:0][7:0] obdr_bytes_t;

    // what one word does: results pushed and the state it leaves
    typedef struct packed {
        logic [1:0]  num_results;
        obdr_out_t   res0;
        obdr_out_t   res1;
        obdr_state_t state_next;
    } obdr_step_t;

    function automatic obdr_out_t make_result(logic kind, logic [10:0] id,
                                              logic [3:0] len, obdr_bytes_t b,
                                              logic last);
        obdr_out_t r;
        r.out_kind   = kind;
        r.out_id     = id;
        r.out_len    = len;
        r.out_b0     = b[0];
        r.out_b1     = b[1];
        r.out_b2     = b[2];
        r.out_b3     = b[3];
        r.out_b4     = b[4];
        r.out_b5     = b[5];
        r.out_b6     = b[6];
        r.out_b7     = b[7];
        r.last_chunk = last;
        return r;
    endfunction

endpackage

/* sv/obdr_frame_decode.sv */
// ----------------------------------------------------------------------------
// obdr_frame_decode
// Classifies one registered word against the answer state and forms its
// results and the next state.
// ----------------------------------------------------------------------------
module obdr_frame_decode
    import obdr_pkg::*;
(
    input  obdr_in_t    item,
    input  obdr_state_t state,
    input  obdr_cfg_t   cfg,
    output obdr_step_t  step
);

    // bytes d[off+i] for i < n, zero elsewhere
    function automatic obdr_bytes_t pick_bytes(obdr_bytes_t d, logic [1:0] off,
                                               logic [3:0] n);
        obdr_bytes_t r;
        logic [3:0]  idx;
        for (int i = 0; i < 8; i++)
        begin
            idx = 4'(i) + {2'b00, off};
            r[i] = ((4'(i) < n) && (idx < MAX_FRAME_BYTES)) ? d[idx[2:0]] : 8'h00;
        end
        return r;
    endfunction

    obdr_bytes_t d;
    obdr_bytes_t req_buf;
    obdr_bytes_t fc_buf;
    logic [3:0]  flen;
    logic [3:0]  pid_cnt;
    logic [3:0]  avail1;
    logic [3:0]  avail2;
    logic [7:0]  pci;
    logic [3:0]  n_single;
    logic [3:0]  n_first;
    logic [7:0]  remaining;
    logic [3:0]  n_consec;
    logic [7:0]  br_consec;
    logic        first_done;
    logic        consec_done;

    always_comb
    begin
        d = {item.data_b7, item.data_b6, item.data_b5, item.data_b4,
             item.data_b3, item.data_b2, item.data_b1, item.data_b0};
        pci  = item.data_b0;
        flen = (item.frame_len > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : item.frame_len;
        avail1 = (flen > 4'd0) ? flen - 4'd1 : 4'd0;
        avail2 = (flen > 4'd2) ? flen - 4'd2 : 4'd0;

        // request frame
        pid_cnt = (item.frame_len > MAX_PIDS) ? MAX_PIDS : item.frame_len;
        req_buf = '0;
        req_buf[0] = {4'h0, pid_cnt} + 8'd1;
        req_buf[1] = cfg.service_code;
        for (int i = 0; i < 6; i++)
        begin
            req_buf[i + 2] = (4'(i) < pid_cnt) ? d[i] : 8'h00;
        end

        fc_buf = '0;
        fc_buf[0] = PCI_FLOW_CONTROL;

        n_single = (pci[3:0] < avail1) ? pci[3:0] : avail1;

        // avail2 never exceeds six
        n_first    = ({4'h0, avail2} < item.data_b1) ? avail2 : item.data_b1[3:0];
        first_done = ({4'h0, n_first} >= item.data_b1);

        remaining   = state.total_length - state.bytes_received;
        n_consec    = ({4'h0, avail1} < remaining) ? avail1 : remaining[3:0];
        br_consec   = state.bytes_received + {4'h0, n_consec};
        consec_done = (br_consec >= state.total_length);
    end

    always_comb
    begin
        step.num_results = 2'd0;
        step.res0        = '0;
        step.res1        = '0;
        step.state_next  = state;

        if (item.req_type == REQ_START)
        begin
            step.num_results = 2'd1;
            step.res0 = make_result(KIND_FRAME, cfg.request_id, pid_cnt + 4'd2,
                                    req_buf, 1'b0);
            step.state_next.awaiting_answer = 1'b1;
            step.state_next.in_multi_frame  = 1'b0;
            step.state_next.total_length    = 8'h00;
            step.state_next.bytes_received  = 8'h00;
        end
        else if (state.awaiting_answer && (item.frame_id == cfg.response_id))
        begin
            if (pci[7:4] == PCI_SINGLE_NIBBLE)
            begin
                step.num_results = 2'd1;
                step.res0 = make_result(KIND_CHUNK, 11'h000, n_single,
                                        pick_bytes(d, 2'd1, n_single), 1'b1);
                step.state_next.awaiting_answer = 1'b0;
                step.state_next.in_multi_frame  = 1'b0;
            end
            else if (pci == PCI_FIRST_FRAME)
            begin
                step.num_results = 2'd2;
                step.res0 = make_result(KIND_CHUNK, 11'h000, n_first,
                                        pick_bytes(d, 2'd2, n_first), first_done);
                step.res1 = make_result(KIND_FRAME, cfg.flow_control_id, 4'd1,
                                        fc_buf, 1'b0);
                step.state_next.total_length   = item.data_b1;
                step.state_next.bytes_received = {4'h0, n_first};
                step.state_next.in_multi_frame = !first_done;
                if (first_done)
                begin
                    step.state_next.awaiting_answer = 1'b0;
                end
            end
            else if ((pci[7:4] == PCI_CONSEC_NIBBLE) && state.in_multi_frame)
            begin
                step.num_results = 2'd1;
                step.res0 = make_result(KIND_CHUNK, 11'h000, n_consec,
                                        pick_bytes(d, 2'd1, n_consec), consec_done);
                step.state_next.bytes_received = br_consec;
                if (consec_done)
                begin
                    step.state_next.awaiting_answer = 1'b0;
                    step.state_next.in_multi_frame  = 1'b0;
                end
            end
        end
    end

endmodule

/* sv/obdr_result_queue.sv */
// ----------------------------------------------------------------------------
// obdr_result_queue
// Small result queue: takes up to two words per cycle, gives one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module obdr_result_queue
    import obdr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_num,
    input  obdr_out_t  push0,
    input  obdr_out_t  push1,
    output logic       room_for_two,
    output logic       out_valid,
    input  logic       out_ready,
    output obdr_out_t  out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    obdr_out_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic             pop;

    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
    assign out_valid    = (count_reg != '0);
    assign out_data     = entry_reg[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign room_for_two = (count_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case (push_num)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_next = count_reg + CNT_W'(push_num) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_num == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push1;
        end
    end

endmodule

/* sv/obd_request_isotp_reassembly_unit.sv */
// ----------------------------------------------------------------------------
// obd_request_isotp_reassembly_unit
// Sends diagnostic requests and reassembles the segmented answer frames into
// a stream of payload chunks, with the flow-control frame after a first frame.
// ----------------------------------------------------------------------------
// path: input register, decode, then a result queue of four words by default;
// a result word is offered by the queue once its input word has been decoded
// throughput: one input word per cycle while the queue has room for two results;
//   a first frame gives two result words, which leave by the single output port
// reset: registers to their defaults, answer state cleared, queue empty
module obd_request_isotp_reassembly_unit
    import obdr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  obdr_in_t    in_data,
    // result words
    output logic        out_valid,
    input  logic        out_ready,
    output obdr_out_t   out_data,
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    obdr_cfg_t   cfg_reg;
    obdr_state_t state_reg;
    obdr_in_t    item_reg;
    logic        item_valid_reg;
    obdr_step_t  step;
    logic        room_for_two;
    logic        fire;
    logic [1:0]  push_num;

    // a word is processed once the queue can take both of its possible results
    assign fire     = item_valid_reg && room_for_two;
    assign in_ready = !item_valid_reg || fire;
    assign push_num = fire ? step.num_results : 2'd0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.request_id      <= REQUEST_ID_RST;
            cfg_reg.response_id     <= RESPONSE_ID_RST;
            cfg_reg.flow_control_id <= FLOW_CONTROL_ID_RST;
            cfg_reg.service_code    <= SERVICE_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REQUEST_ID:      cfg_reg.request_id      <= cfg_data;
                REG_RESPONSE_ID:     cfg_reg.response_id     <= cfg_data;
                REG_FLOW_CONTROL_ID: cfg_reg.flow_control_id <= cfg_data;
                REG_SERVICE_CODE:    cfg_reg.service_code    <= cfg_data[7:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // input register: holds one word until the decode stage can push its results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    // answer state, advanced once per processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= step.state_next;
        end
    end

    obdr_frame_decode u_decode (
        .item  (item_reg),
        .state (state_reg),
        .cfg   (cfg_reg),
        .step  (step)
    );

    // queue decouples the output handshake from the decode stage
    obdr_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_num     (push_num),
        .push0        (step.res0),
        .push1        (step.res1),
        .room_for_two (room_for_two),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the diagnostic request and answer reassembly unit:
// a directed opener, then several register settings each followed by random
// request and answer sessions, with every result word checked in order.
// ----------------------------------------------------------------------------
module tb_top;
    import obdr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 370;
    localparam int SETTLE_CYCLES  = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    obdr_in_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    obdr_out_t   out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_REQUEST_ID;
    logic [10:0] cfg_data = '0;

    obd_request_isotp_reassembly_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // words waiting to be offered, and result words still owed by the unit
    obdr_in_t  queued_in_words [$];
    obdr_out_t due_out_words [$];

    int  fail_count = 0;
    int  useful_words = 0;
    bit  quiet_tail = 1'b0;   // no idling on either side in the closing phase
    int  in_gap = 0;
    int  out_stall = 0;
    int  idle_cycles = 0;

    // bench copy of the registers
    logic [10:0] req_id_r  = REQUEST_ID_RST;
    logic [10:0] resp_id_r = RESPONSE_ID_RST;
    logic [10:0] fc_id_r   = FLOW_CONTROL_ID_RST;
    logic [7:0]  svc_r     = SERVICE_CODE_RST;

    // bench copy of the answer state
    bit ans_pending  = 1'b0;
    bit multi_active = 1'b0;
    int answer_total = 0;
    int answer_seen  = 0;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic int at_most(int a, int b);
        return (a < b) ? a : b;
    endfunction

    function automatic obdr_out_t pack_out(logic kind, logic [10:0] id, int len,
                                           logic [7:0] pay [8], logic last);
        obdr_out_t r;
        r.out_kind   = kind;
        r.out_id     = id;
        r.out_len    = len[3:0];
        r.out_b0     = pay[0];
        r.out_b1     = pay[1];
        r.out_b2     = pay[2];
        r.out_b3     = pay[3];
        r.out_b4     = pay[4];
        r.out_b5     = pay[5];
        r.out_b6     = pay[6];
        r.out_b7     = pay[7];
        r.last_chunk = last;
        return r;
    endfunction

    // works out the result words of one accepted word and moves the answer
    // state on; bytes beyond the length stay zero
    function automatic void reassemble_word(obdr_in_t w);
        logic [7:0] d [8];
        logic [7:0] pay [8];
        logic [7:0] fc [8];
        int flen;
        int n;
        int avail;
        bit done;
        d = '{w.data_b0, w.data_b1, w.data_b2, w.data_b3,
              w.data_b4, w.data_b5, w.data_b6, w.data_b7};
        for (int i = 0; i < 8; i++)
        begin
            pay[i] = 8'h00;
            fc[i]  = 8'h00;
        end
        flen = at_most(int'(w.frame_len), int'(MAX_FRAME_BYTES));

        if (w.req_type == REQ_START)
        begin
            // request frame: length byte, service byte, pids clamped to six
            n = at_most(int'(w.frame_len), int'(MAX_PIDS));
            pay[0] = 8'(n + 1);
            pay[1] = svc_r;
            for (int i = 0; i < n; i++)
                pay[2 + i] = d[i];
            due_out_words.push_back(pack_out(KIND_FRAME, req_id_r, n + 2, pay, 1'b0));
            ans_pending  = 1'b1;
            multi_active = 1'b0;
            answer_total = 0;
            answer_seen  = 0;
        end
        else if (ans_pending && w.frame_id == resp_id_r)
        begin
            if (d[0][7:4] == PCI_SINGLE_NIBBLE)
            begin
                // single frame: length nibble clamped to the bytes present
                avail = (flen > 0) ? flen - 1 : 0;
                n = at_most(int'(d[0]), avail);
                for (int i = 0; i < n; i++)
                    pay[i] = d[1 + i];
                due_out_words.push_back(pack_out(KIND_CHUNK, 11'd0, n, pay, 1'b1));
                ans_pending  = 1'b0;
                multi_active = 1'b0;
            end
            else if (d[0] == PCI_FIRST_FRAME)
            begin
                // first frame: chunk, then the flow-control frame
                answer_total = int'(d[1]);
                avail = (flen > 2) ? flen - 2 : 0;
                n = at_most(at_most(avail, 6), answer_total);
                for (int i = 0; i < n; i++)
                    pay[i] = d[2 + i];
                answer_seen = n;
                done = (answer_seen >= answer_total);
                due_out_words.push_back(pack_out(KIND_CHUNK, 11'd0, n, pay, done));
                fc[0] = PCI_FLOW_CONTROL;
                due_out_words.push_back(pack_out(KIND_FRAME, fc_id_r, 1, fc, 1'b0));
                if (done)
                begin
                    ans_pending  = 1'b0;
                    multi_active = 1'b0;
                end
                else
                    multi_active = 1'b1;
            end
            else if (d[0][7:4] == PCI_CONSEC_NIBBLE && multi_active)
            begin
                // consecutive frame: clamped to seven, present and missing bytes
                avail = (flen > 0) ? flen - 1 : 0;
                n = at_most(at_most(avail, 7), answer_total - answer_seen);
                for (int i = 0; i < n; i++)
                    pay[i] = d[1 + i];
                answer_seen += n;
                done = (answer_seen >= answer_total);
                due_out_words.push_back(pack_out(KIND_CHUNK, 11'd0, n, pay, done));
                if (done)
                begin
                    ans_pending  = 1'b0;
                    multi_active = 1'b0;
                end
            end
            // any other protocol byte, or a consecutive frame out of place: ignored
        end
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    function automatic void check_field(string fname, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_word(obdr_out_t got);
        obdr_out_t want;
        if (due_out_words.size() == 0)
        begin
            $error("result word with nothing expected: 0x%0h", got);
            fail_count++;
            return;
        end
        want = due_out_words.pop_front();
        check_field("out_kind",   32'(want.out_kind),   32'(got.out_kind));
        check_field("out_id",     32'(want.out_id),     32'(got.out_id));
        check_field("out_len",    32'(want.out_len),    32'(got.out_len));
        check_field("out_b0",     32'(want.out_b0),     32'(got.out_b0));
        check_field("out_b1",     32'(want.out_b1),     32'(got.out_b1));
        check_field("out_b2",     32'(want.out_b2),     32'(got.out_b2));
        check_field("out_b3",     32'(want.out_b3),     32'(got.out_b3));
        check_field("out_b4",     32'(want.out_b4),     32'(got.out_b4));
        check_field("out_b5",     32'(want.out_b5),     32'(got.out_b5));
        check_field("out_b6",     32'(want.out_b6),     32'(got.out_b6));
        check_field("out_b7",     32'(want.out_b7),     32'(got.out_b7));
        check_field("last_chunk", 32'(want.last_chunk), 32'(got.last_chunk));
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers queued words, predicts each one as it is taken
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                reassemble_word(in_data);
            // a word on offer is held until taken
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (queued_in_words.size() == 0)
                    in_valid <= 1'b0;
                else if (!quiet_tail && $urandom_range(0, 5) == 0)
                begin
                    // idle burst, with in_gap drawn at random
                    in_gap = $urandom_range(0, 6);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data  <= queued_in_words.pop_front();
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure, checks every word taken
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_word(out_data);
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                // stall burst, with out_stall drawn at random
                out_stall = $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog: too long without a handshake on either side ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no handshake for %0d cycles, %0d result words outstanding",
                       WATCHDOG_LIMIT, due_out_words.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic obdr_in_t mk_word(logic t, logic [10:0] id, logic [3:0] len,
                                         logic [7:0] b0, logic [7:0] b1,
                                         logic [7:0] fill);
        obdr_in_t w;
        w.req_type  = t;
        w.frame_id  = id;
        w.frame_len = len;
        w.data_b0   = b0;
        w.data_b1   = b1;
        w.data_b2   = fill;
        w.data_b3   = fill;
        w.data_b4   = fill;
        w.data_b5   = fill;
        w.data_b6   = fill;
        w.data_b7   = fill;
        return w;
    endfunction

    // word with random bytes after the first two
    function automatic obdr_in_t rnd_word(logic t, logic [10:0] id, logic [3:0] len,
                                          logic [7:0] b0, logic [7:0] b1);
        obdr_in_t w;
        w = mk_word(t, id, len, b0, b1, 8'h00);
        {w.data_b2, w.data_b3, w.data_b4, w.data_b5} = $urandom;
        {w.data_b6, w.data_b7} = 16'($urandom_range(0, 65535));
        return w;
    endfunction

    function automatic void push_word(obdr_in_t w);
        queued_in_words.push_back(w);
        // words with a foreign id, which the unit drops, are not counted
        if (w.req_type == REQ_START || w.frame_id == resp_id_r)
            useful_words++;
    endfunction

    // frame length: mostly a full frame, sometimes anything the field holds
    function automatic logic [3:0] pick_len();
        return ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : MAX_FRAME_BYTES;
    endfunction

    function automatic obdr_in_t noise_word(logic [10:0] rid);
        logic [10:0] id;
        id = ($urandom_range(0, 1) == 0) ? rid : 11'($urandom_range(0, 2047));
        return rnd_word(REQ_FRAME, id, 4'($urandom_range(0, 15)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endfunction

    // one request and, mostly, a well-formed answer with random content
    task automatic queue_session(input logic [10:0] rid);
        int style;
        int total;
        int sent;
        int seq;
        int pci;
        int flen;
        style = $urandom_range(0, 9);
        push_word(rnd_word(REQ_START, 11'($urandom_range(0, 2047)),
                           4'(($urandom_range(0, 9) == 0) ? $urandom_range(7, 15)
                                                          : $urandom_range(0, 6)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
        if (style < 4)
        begin
            // single frame answer, now and then with a short or odd length
            pci  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 7);
            flen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : at_most(pci + 1, 15);
            push_word(rnd_word(REQ_FRAME, rid, 4'(flen), 8'(pci),
                               8'($urandom_range(0, 255))));
        end
        else if (style < 9)
        begin
            // segmented answer; long totals are kept rare
            total = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
            push_word(rnd_word(REQ_FRAME, rid, pick_len(), PCI_FIRST_FRAME, 8'(total)));
            sent = 6;
            seq  = 1;
            while (sent < total && $urandom_range(0, 29) != 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_word(noise_word(rid));
                push_word(rnd_word(REQ_FRAME, rid, pick_len(),
                                   {PCI_CONSEC_NIBBLE, seq[3:0]},
                                   8'($urandom_range(0, 255))));
                sent += 7;
                seq++;
            end
            // a stray consecutive frame after the answer
            if ($urandom_range(0, 4) == 0)
                push_word(rnd_word(REQ_FRAME, rid, pick_len(),
                                   {PCI_CONSEC_NIBBLE, seq[3:0]},
                                   8'($urandom_range(0, 255))));
        end
        else
            repeat (3) push_word(noise_word(rid));
    endtask

    // register writes, one per cycle, only while the unit is idle
    task automatic program_regs(input logic [10:0] rq, input logic [10:0] rs,
                                input logic [10:0] fc, input logic [7:0] svc);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_REQUEST_ID;
        cfg_data  <= rq;
        @(posedge clk);
        cfg_index <= REG_RESPONSE_ID;
        cfg_data  <= rs;
        @(posedge clk);
        cfg_index <= REG_FLOW_CONTROL_ID;
        cfg_data  <= fc;
        @(posedge clk);
        cfg_index <= REG_SERVICE_CODE;
        cfg_data  <= {3'b000, svc};
        @(posedge clk);
        cfg_we <= 1'b0;
        req_id_r  = rq;
        resp_id_r = rs;
        fc_id_r   = fc;
        svc_r     = svc;
    endtask

    // all words taken, all results seen, then a settling wait for dropped words
    task automatic wait_drained();
        do
            @(negedge clk);
        while (queued_in_words.size() != 0 || in_valid || due_out_words.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed opener at the reset register values
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd8, 8'h07, 8'hFF, 8'hFF)); // no request yet
        push_word(mk_word(REQ_START, 11'd0, 4'd0, 8'hFF, 8'hFF, 8'hFF));           // no pids
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd8, 8'h07, 8'hFF, 8'hFF)); // full single frame
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd8, 8'h03, 8'h11, 8'h22)); // answer over
        push_word(mk_word(REQ_START, 11'h7FF, 4'd6, 8'h0C, 8'h0D, 8'h00));        // six pids
        push_word(mk_word(REQ_FRAME, 11'h000, 4'd8, 8'h02, 8'h41, 8'h00));        // foreign ids
        push_word(mk_word(REQ_FRAME, 11'h7FF, 4'd8, 8'h02, 8'h41, 8'hFF));
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd3, 8'h05, 8'h41, 8'hAA)); // nibble > present
        push_word(mk_word(REQ_START, 11'd0, 4'd7, 8'h01, 8'h02, 8'h5A));          // pid count clamped
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd0, 8'h00, 8'h00, 8'h00)); // empty frame
        push_word(mk_word(REQ_START, 11'd0, 4'd15, 8'hFF, 8'h00, 8'hA5));         // length field max
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd15, 8'h0F, 8'h00, 8'hFF)); // length above 8
        push_word(mk_word(REQ_START, 11'd0, 4'd6, 8'h0C, 8'h0D, 8'h05));
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd8, PCI_FIRST_FRAME, 8'd20, 8'h33));
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd1, 8'h21, 8'h00, 8'h00)); // zero-byte chunk
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd8, PCI_FLOW_CONTROL, 8'h01, 8'h01)); // other pci
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd8, 8'hFF, 8'hFF, 8'hFF));
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd8, 8'h22, 8'h81, 8'h7E));
        push_word(mk_word(REQ_START, 11'd0, 4'd2, 8'h0D, 8'h10, 8'h00));          // abandons answer
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd8, 8'h23, 8'h00, 8'hFF)); // not segmented
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd8, PCI_FIRST_FRAME, 8'd3, 8'hC3)); // done at once
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd8, 8'h21, 8'h00, 8'h00)); // after the answer
        push_word(mk_word(REQ_START, 11'd0, 4'd1, 8'h0C, 8'h00, 8'h00));
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd2, PCI_FIRST_FRAME, 8'd0, 8'h00)); // zero total
        push_word(mk_word(REQ_START, 11'd0, 4'd1, 8'h05, 8'h00, 8'h00));
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd15, PCI_FIRST_FRAME, 8'd9, 8'h99));
        push_word(mk_word(REQ_FRAME, RESPONSE_ID_RST, 4'd8, 8'h2F, 8'h44, 8'h55)); // clamped to missing
        wait_drained();

        // random sessions under several register settings, extremes included
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1: program_regs(11'h000, 11'h000, 11'h000, 8'h00);
                2: program_regs(11'h7FF, 11'h7FF, 11'h7FF, 8'hFF);
                default: program_regs(11'($urandom_range(0, 2047)),
                                      11'($urandom_range(0, 2047)),
                                      11'($urandom_range(0, 2047)),
                                      8'($urandom_range(0, 255)));
            endcase
            quiet_tail = (phase == 4);
            useful_words = 0;
            @(negedge clk);
            while (useful_words < PHASE_WORDS)
                queue_session(resp_id_r);
            wait_drained();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
sv/obdr_pkg.sv
sv/obdr_frame_decode.sv
sv/obdr_result_queue.sv
sv/obd_request_isotp_reassembly_unit.sv
test/tb_top.sv
